// ===== src/byte_pattern_scanner_macros.svh =====
// Assertion macros for the byte pattern scanner.
// Included by byte_pattern_scanner, which checks its own logic; no other dependencies.
`ifndef BYTE_PATTERN_SCANNER_MACROS_SVH
`define BYTE_PATTERN_SCANNER_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define BPS_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bps check failed");
// next-cycle implication
`define BPS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bps check failed");
`else
`define BPS_ASSERT_NOW(lbl, clk, rst, ante, cons)
`define BPS_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== src/bps_pkg.sv =====
// Shared types and constants of the byte pattern scanner.
// No dependencies; used by bps_cell and byte_pattern_scanner.
package bps_pkg;

  localparam int BYTE_W      = 8;
  localparam int ADDR_W      = 48;
  localparam int COUNT_W     = 32;
  localparam int LEN_W       = 5;
  localparam int PAT_MAX     = 16;
  localparam int PAT_IDX_W   = 4;
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_INDEX_W = 2;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_LENGTH = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_LOW    = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_HIGH   = 2'd2;

  typedef logic [BYTE_W-1:0] byte_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic [ADDR_W-1:0] byte_address;
    logic              region_first;
  } scan_item_t;

  typedef struct packed {
    logic               match_found;
    logic [ADDR_W-1:0]  match_address;
    logic [COUNT_W-1:0] match_count;
  } result_item_t;

  // per-cell compare control
  typedef struct packed {
    logic  active;
    byte_t target;
  } cell_ctrl_t;

endpackage

// ===== src/bps_cell.sv =====
// One window cell: holds one byte of the sliding window and compares the byte
// moving into it with its pattern byte. Depends on bps_pkg.
module bps_cell (
  input  logic               clk,
  input  logic               load,
  input  bps_pkg::byte_t     byte_in,
  input  bps_pkg::cell_ctrl_t ctrl,
  output bps_pkg::byte_t     byte_out,
  output logic               hit
);

  bps_pkg::byte_t held;

  always_ff @(posedge clk) begin
    if (load) begin
      held <= byte_in;
    end
  end

  // inactive cells lie outside the pattern and always agree
  assign hit      = !ctrl.active || (byte_in == ctrl.target);
  assign byte_out = held;

endmodule

// ===== src/byte_pattern_scanner.sv =====
// Byte pattern scanner: one result per byte, registered at the edge that takes
// the byte; it shows on the result port the next cycle.
// Throughput is one byte per cycle unless stalled; the cell row compares in parallel.
// A byte is taken while the result register is empty or being emptied.
// Reset clears pattern_length to 1, patterns, region fill, match count and result valid.
`include "byte_pattern_scanner_macros.svh"
module byte_pattern_scanner #(
  parameter int MAX_PATTERN = 16,
  parameter int ADDR_BITS   = 48
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                scan_valid,
  output logic                                scan_stall,
  input  bps_pkg::scan_item_t                 scan_item,
  output logic                                result_valid,
  input  logic                                result_stall,
  output bps_pkg::result_item_t               result_item,
  input  logic                                cfg_write,
  input  logic [bps_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [bps_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int NCELL  = (MAX_PATTERN < bps_pkg::PAT_MAX) ? MAX_PATTERN : bps_pkg::PAT_MAX;
  localparam int FILL_W = $clog2(NCELL + 1);
  localparam int AW     = (ADDR_BITS < bps_pkg::ADDR_W) ? ADDR_BITS : bps_pkg::ADDR_W;

  localparam logic [FILL_W-1:0]         FILL_MAX = FILL_W'(NCELL);
  localparam logic [bps_pkg::LEN_W-1:0] LEN_CAP  = bps_pkg::LEN_W'(NCELL);

  // configuration registers
  logic [bps_pkg::LEN_W-1:0]      pattern_length;
  logic [bps_pkg::CFG_DATA_W-1:0] pattern_low;
  logic [bps_pkg::CFG_DATA_W-1:0] pattern_high;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length <= bps_pkg::LEN_W'(1);
      pattern_low    <= '0;
      pattern_high   <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        bps_pkg::CFG_PATTERN_LENGTH: pattern_length <= cfg_data[bps_pkg::LEN_W-1:0];
        bps_pkg::CFG_PATTERN_LOW:    pattern_low    <= cfg_data;
        bps_pkg::CFG_PATTERN_HIGH:   pattern_high   <= cfg_data;
        default: ;
      endcase
    end
  end

  bps_pkg::byte_t pattern_byte [bps_pkg::PAT_MAX];

  for (genvar p = 0; p < bps_pkg::PAT_MAX; p++) begin : g_pat
    if (p < 8) begin : g_lo
      assign pattern_byte[p] = pattern_low[8*p +: 8];
    end else begin : g_hi
      assign pattern_byte[p] = pattern_high[8*(p-8) +: 8];
    end
  end

  logic [bps_pkg::LEN_W-1:0] len_eff;
  assign len_eff = (pattern_length > LEN_CAP) ? LEN_CAP : pattern_length;

  // handshake
  logic accept;
  assign scan_stall = rst || (result_valid && result_stall);
  assign accept     = scan_valid && !scan_stall;

  // cell row: byte j of the window after this transfer is the byte entering cell j
  bps_pkg::byte_t      win [NCELL];
  bps_pkg::byte_t      win_in [NCELL];
  bps_pkg::cell_ctrl_t cell_ctrl [NCELL];
  logic [NCELL-1:0]    hit;

  for (genvar j = 0; j < NCELL; j++) begin : g_cell
    logic [bps_pkg::LEN_W-1:0] idx_full;

    assign idx_full = len_eff - bps_pkg::LEN_W'(1) - bps_pkg::LEN_W'(j);
    assign cell_ctrl[j].active = bps_pkg::LEN_W'(j) < len_eff;
    assign cell_ctrl[j].target = pattern_byte[idx_full[bps_pkg::PAT_IDX_W-1:0]];

    if (j == 0) begin : g_head
      assign win_in[j] = scan_item.data_byte;
    end else begin : g_link
      assign win_in[j] = win[j-1];
    end

    bps_cell u_cell (
      .clk      (clk),
      .load     (accept),
      .byte_in  (win_in[j]),
      .ctrl     (cell_ctrl[j]),
      .byte_out (win[j]),
      .hit      (hit[j])
    );
  end

  // region fill, saturating at the row length
  logic [FILL_W-1:0] fill;
  logic [FILL_W-1:0] fill_next;

  always_comb begin
    if (scan_item.region_first) begin
      fill_next = FILL_W'(1);
    end else if (fill < FILL_MAX) begin
      fill_next = fill + FILL_W'(1);
    end else begin
      fill_next = fill;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (accept) begin
      fill <= fill_next;
    end
  end

  logic found;
  assign found = (len_eff != '0) && (bps_pkg::LEN_W'(fill_next) >= len_eff) && (&hit);

  logic [AW-1:0] start_addr;
  assign start_addr = scan_item.byte_address[AW-1:0]
                    - AW'(len_eff - bps_pkg::LEN_W'(1));

  // match count and result register
  logic [bps_pkg::COUNT_W-1:0] match_cnt;
  logic [bps_pkg::COUNT_W-1:0] match_cnt_next;

  assign match_cnt_next = (found && (match_cnt != '1)) ? match_cnt + 1'b1 : match_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      match_cnt <= '0;
    end else if (accept) begin
      match_cnt <= match_cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (accept) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result_item.match_found   <= found;
      result_item.match_address <= found ? bps_pkg::ADDR_W'(start_addr) : '0;
      result_item.match_count   <= match_cnt_next;
    end
  end

  `BPS_ASSERT_NOW(a_found_counts, clk, rst, result_valid && result_item.match_found, result_item.match_count != '0)
  `BPS_ASSERT_NOW(a_miss_addr_zero, clk, rst, result_valid && !result_item.match_found, result_item.match_address == '0)
  `BPS_ASSERT_NEXT(a_miss_holds_count, clk, rst, accept && !found, match_cnt == $past(match_cnt))
  `BPS_ASSERT_NOW(a_full_stalls, clk, rst, result_valid && result_stall, scan_stall)
  `BPS_ASSERT_NOW(a_fill_bound, clk, rst, 1'b1, fill <= FILL_MAX)

endmodule
